// ===== sv/urc_pkg.sv =====
package urc_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 1024;
    localparam int QUEUE_DEPTH         = 4;
    localparam int HEADER_BYTES        = 8;

    localparam logic [31:0] LOCAL_ADDRESS_RST = 32'h0000_0000;
    localparam logic [15:0] SERVICE_PORT_RST  = 16'd53;
    localparam logic [15:0] PROTOCOL_WORD     = 16'h0011;

    // configuration register indexes
    localparam logic REG_LOCAL_ADDRESS = 1'b0;
    localparam logic REG_SERVICE_PORT  = 1'b1;

    typedef enum logic [2:0] {
        VERDICT_SERVICE  = 3'd0,
        VERDICT_OTHER    = 3'd1,
        VERDICT_SHORT    = 3'd2,
        VERDICT_LENGTH   = 3'd3,
        VERDICT_CHECKSUM = 3'd4,
        VERDICT_OVERSIZE = 3'd5
    } urc_verdict_t;

    // everything the back end needs about one finished frame
    typedef struct packed {
        logic        oversize;
        logic        short_frame;
        logic        len_over;
        logic [31:0] sum;
        logic [7:0]  held;
        logic [15:0] src;
        logic [15:0] dst;
        logic [15:0] len;
        logic [15:0] csum;
        logic [31:0] sender;
    } urc_summary_t;

    typedef struct packed {
        logic oversize;
        logic too_short;
        logic len_over;
        logic csum_zero;
        logic dst_match;
    } urc_flags_t;

endpackage

// ===== sv/udp_receive_checker.sv =====
// UDP receive checker.
// Input stream: one datagram byte per word on s_tdata[7:0], sender IPv4 address
// on s_tdata[39:8] (held over the datagram), s_tlast on the final byte of the frame.
// Output stream: one verdict word per frame: service port, other port, too short,
// length beyond frame, bad checksum or oversize, with the ports and payload length.
// Config channel: index 0 writes the local IPv4 address, index 1 the service port;
// write only while no frame is in flight. cfg_ready is always high.
// Throughput: one byte per cycle, frames back to back, down to one-byte frames;
// the per-byte path is one 32-bit add of the running ones' complement sum.
// Path: after the last byte is accepted, the verdict passes through the summary
// queue, two sum stages, one fold stage and the output register.
// Stall: while a verdict waits with m_tready low the output word holds and the
// checker pipeline freezes; once the 4-entry summary queue fills, s_tready drops.
// Reset: local address 0, service port 53, frame state and pipeline cleared.
module udp_receive_checker #(
    parameter int MAX_FRAME_BYTES = urc_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // data_byte[7:0], sender_address[39:8]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // verdict[2:0], source_port[18:3],
                                   // destination_port[34:19], payload_length[44:35]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    logic [31:0]           local_address_reg;
    logic [15:0]           service_port_reg;
    logic                  push;
    logic                  q_ready;
    logic                  q_valid;
    logic                  q_pop;
    urc_pkg::urc_summary_t summary;
    urc_pkg::urc_summary_t q_head;
    logic [2:0]            verdict;
    logic [15:0]           source_port;
    logic [15:0]           destination_port;
    logic [9:0]            payload_length;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_address_reg <= urc_pkg::LOCAL_ADDRESS_RST;
            service_port_reg  <= urc_pkg::SERVICE_PORT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                urc_pkg::REG_LOCAL_ADDRESS: local_address_reg <= cfg_data;
                urc_pkg::REG_SERVICE_PORT:  service_port_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    urc_front #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .data_byte      (s_tdata[7:0]),
        .last_byte      (s_tlast),
        .sender_address (s_tdata[39:8]),
        .q_ready        (q_ready),
        .push           (push),
        .summary        (summary)
    );

    urc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (summary),
        .ready     (q_ready),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    urc_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .q_head           (q_head),
        .q_pop            (q_pop),
        .local_address    (local_address_reg),
        .service_port     (service_port_reg),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .verdict          (verdict),
        .source_port      (source_port),
        .destination_port (destination_port),
        .payload_length   (payload_length)
    );

    assign m_tdata = {3'b000, payload_length, destination_port, source_port, verdict};

endmodule

// ===== sv/urc_front.sv =====
module urc_front #(
    parameter int MAX_FRAME_BYTES = urc_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,
    input  logic [31:0]          sender_address,
    input  logic                 q_ready,
    output logic                 push,
    output urc_pkg::urc_summary_t summary
);

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [31:0]      sum_reg, sum_next;
    logic [7:0]       held_reg, held_next;
    logic [15:0]      src_reg, src_next;
    logic [15:0]      dst_reg, dst_next;
    logic [15:0]      len_reg, len_next;
    logic [15:0]      csum_reg, csum_next;
    logic             oversize;
    logic             in_sum;
    logic [16:0]      frame_len;
    logic             accept;

    assign in_ready = q_ready;
    assign accept   = in_valid && in_ready;
    assign push     = accept && last_byte;

    always_comb
    begin
        pos_next  = pos_reg;
        sum_next  = sum_reg;
        held_next = held_reg;
        src_next  = src_reg;
        dst_next  = dst_reg;
        len_next  = len_reg;
        csum_next = csum_reg;
        in_sum    = 1'b0;
        oversize  = pos_reg >= POS_W'(MAX_FRAME_BYTES);
        if (!oversize)
        begin
            if (pos_reg < POS_W'(urc_pkg::HEADER_BYTES))
            begin
                unique case (pos_reg[2:0])
                    3'd0: src_next  = {data_byte, 8'h00};
                    3'd1: src_next  = {src_reg[15:8], data_byte};
                    3'd2: dst_next  = {data_byte, 8'h00};
                    3'd3: dst_next  = {dst_reg[15:8], data_byte};
                    3'd4: len_next  = {data_byte, 8'h00};
                    3'd5: len_next  = {len_reg[15:8], data_byte};
                    3'd6: csum_next = {data_byte, 8'h00};
                    3'd7: csum_next = {csum_reg[15:8], data_byte};
                    default: ;
                endcase
            end
            // sum covers the header up to the length field, then the first length bytes
            in_sum = (pos_reg < POS_W'(6)) || (16'(pos_reg) < len_next);
            if (in_sum)
            begin
                if (pos_reg[0])
                    sum_next = sum_reg + 32'({held_reg, data_byte});
                else
                    held_next = data_byte;
            end
            pos_next = pos_reg + 1'b1;
        end
    end

    always_comb
    begin
        frame_len           = 17'(pos_reg) + 17'd1;
        summary.oversize    = oversize;
        summary.short_frame = pos_reg < POS_W'(urc_pkg::HEADER_BYTES - 1);
        summary.len_over    = 17'(len_next) > frame_len;
        summary.sum         = sum_next;
        summary.held        = held_next;
        summary.src         = src_next;
        summary.dst         = dst_next;
        summary.len         = len_next;
        summary.csum        = csum_next;
        summary.sender      = sender_address;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            sum_reg  <= '0;
            held_reg <= '0;
            src_reg  <= '0;
            dst_reg  <= '0;
            len_reg  <= '0;
            csum_reg <= '0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                pos_reg  <= '0;
                sum_reg  <= '0;
                held_reg <= '0;
                src_reg  <= '0;
                dst_reg  <= '0;
                len_reg  <= '0;
                csum_reg <= '0;
            end
            else
            begin
                pos_reg  <= pos_next;
                sum_reg  <= sum_next;
                held_reg <= held_next;
                src_reg  <= src_next;
                dst_reg  <= dst_next;
                len_reg  <= len_next;
                csum_reg <= csum_next;
            end
        end
    end

`ifndef ASSERT_OFF
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (pos_reg == '0 && sum_reg == '0))
        else $error("frame state not cleared after last word");
`endif

endmodule

// ===== sv/urc_queue.sv =====
module urc_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  urc_pkg::urc_summary_t push_data,
    output logic                  ready,
    input  logic                  pop,
    output logic                  valid,
    output urc_pkg::urc_summary_t head
);

    localparam int DEPTH = urc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    urc_pkg::urc_summary_t entries [DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]      count_reg;
    logic                  do_pop;

    assign ready  = count_reg != CNT_W'(DEPTH);
    assign valid  = count_reg != '0;
    assign head   = entries[rd_ptr_reg];
    assign do_pop = pop && valid;

    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            unique case ({push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ready)
        else $error("push into full queue");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count out of range");
`endif

endmodule

// ===== sv/urc_back.sv =====
module urc_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  urc_pkg::urc_summary_t q_head,
    output logic                  q_pop,
    input  logic [31:0]           local_address,
    input  logic [15:0]           service_port,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [2:0]            verdict,
    output logic [15:0]           source_port,
    output logic [15:0]           destination_port,
    output logic [9:0]            payload_length
);

    logic                 adv;

    logic                 s1_valid_reg;
    urc_pkg::urc_flags_t  s1_flags_reg;
    logic [33:0]          s1_a_reg;
    logic [18:0]          s1_b_reg;
    logic [15:0]          s1_src_reg, s1_dst_reg;
    logic [9:0]           s1_pay_reg;

    logic                 s2_valid_reg;
    urc_pkg::urc_flags_t  s2_flags_reg;
    logic [34:0]          s2_total_reg;
    logic [15:0]          s2_src_reg, s2_dst_reg;
    logic [9:0]           s2_pay_reg;

    logic                 s3_valid_reg;
    urc_pkg::urc_flags_t  s3_flags_reg;
    logic [17:0]          s3_fold_reg;
    logic [15:0]          s3_src_reg, s3_dst_reg;
    logic [9:0]           s3_pay_reg;

    logic                 out_valid_reg;
    urc_pkg::urc_verdict_t verdict_reg, verdict_next;
    logic [15:0]          src_reg, dst_reg;
    logic [9:0]           pay_reg, pay_next;

    urc_pkg::urc_flags_t  flags_in;
    logic [33:0]          a_in;
    logic [18:0]          b_in;
    logic [15:0]          pad;
    logic [16:0]          fold2;
    logic                 good;

    // whole pipeline moves together; hold everything while the output waits
    assign adv   = !out_valid_reg || out_ready;
    assign q_pop = adv;

    always_comb
    begin
        flags_in.oversize  = q_head.oversize;
        flags_in.too_short = q_head.short_frame ||
                             (q_head.len < 16'(urc_pkg::HEADER_BYTES));
        flags_in.len_over  = q_head.len_over;
        flags_in.csum_zero = q_head.csum == 16'h0000;
        flags_in.dst_match = q_head.dst == service_port;
        pad  = q_head.len[0] ? {q_head.held, 8'h00} : 16'h0000;
        a_in = 34'(q_head.sum) + 34'(pad) + 34'(q_head.len);
        b_in = 19'(q_head.sender[31:16]) + 19'(q_head.sender[15:0]) +
               19'(local_address[31:16]) + 19'(local_address[15:0]) +
               19'(urc_pkg::PROTOCOL_WORD);
    end

    always_comb
    begin
        // fold a nonzero value below 0x10003 is zero mod 0xFFFF only at 0xFFFF
        fold2    = 17'(s3_fold_reg[15:0]) + 17'(s3_fold_reg[17:16]);
        good     = fold2 == 17'h0FFFF;
        pay_next = '0;
        priority if (s3_flags_reg.oversize)
            verdict_next = urc_pkg::VERDICT_OVERSIZE;
        else if (s3_flags_reg.too_short)
            verdict_next = urc_pkg::VERDICT_SHORT;
        else if (s3_flags_reg.len_over)
            verdict_next = urc_pkg::VERDICT_LENGTH;
        else if (!s3_flags_reg.csum_zero && !good)
            verdict_next = urc_pkg::VERDICT_CHECKSUM;
        else
        begin
            verdict_next = s3_flags_reg.dst_match ? urc_pkg::VERDICT_SERVICE
                                                  : urc_pkg::VERDICT_OTHER;
            pay_next     = s3_pay_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= q_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_flags_reg <= flags_in;
            s1_a_reg     <= a_in;
            s1_b_reg     <= b_in;
            s1_src_reg   <= q_head.src;
            s1_dst_reg   <= q_head.dst;
            s1_pay_reg   <= 10'(q_head.len - 16'(urc_pkg::HEADER_BYTES));

            s2_flags_reg <= s1_flags_reg;
            s2_total_reg <= 35'(s1_a_reg) + 35'(s1_b_reg);
            s2_src_reg   <= s1_src_reg;
            s2_dst_reg   <= s1_dst_reg;
            s2_pay_reg   <= s1_pay_reg;

            s3_flags_reg <= s2_flags_reg;
            s3_fold_reg  <= 18'(s2_total_reg[15:0]) + 18'(s2_total_reg[31:16]) +
                            18'(s2_total_reg[34:32]);
            s3_src_reg   <= s2_src_reg;
            s3_dst_reg   <= s2_dst_reg;
            s3_pay_reg   <= s2_pay_reg;

            verdict_reg  <= verdict_next;
            src_reg      <= s3_src_reg;
            dst_reg      <= s3_dst_reg;
            pay_reg      <= pay_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign verdict          = verdict_reg;
    assign source_port      = src_reg;
    assign destination_port = dst_reg;
    assign payload_length   = pay_reg;

`ifndef ASSERT_OFF
    a_reject_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && verdict_reg != urc_pkg::VERDICT_SERVICE &&
         verdict_reg != urc_pkg::VERDICT_OTHER) |-> (pay_reg == '0))
        else $error("rejected frame reports a payload length");
    a_oversize_wins: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s3_valid_reg && s3_flags_reg.oversize) |=>
        (verdict_reg == urc_pkg::VERDICT_OVERSIZE))
        else $error("oversize frame given a lower verdict");
`endif

endmodule
